// ===== src/framebuffer_blit_engine_core_defines.svh =====
// assertion macros shared by the blit engine
`ifndef FRAMEBUFFER_BLIT_ENGINE_CORE_DEFINES_SVH
`define FRAMEBUFFER_BLIT_ENGINE_CORE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define FBE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition must hold in the cycle after the trigger
`define FBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fbe_pkg.sv =====
// shared types and constants of the blit engine
package fbe_pkg;

  localparam int OP_W       = 2;
  localparam int COORD_IN_W = 12;
  localparam int COORD_W    = 13;
  localparam int PIXEL_W    = 32;
  localparam int COUNT_W    = 17;
  localparam int CFG_W      = 9;
  localparam int ADDR_MAX_W = 24;
  localparam int REG_INDEX_W = 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [REG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_SKIP,
    CMD_WRITE,
    CMD_READ,
    CMD_MOVE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_MV_RD,
    BK_MV_WR
  } bk_state_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [ADDR_MAX_W-1:0]   dst_addr;
    logic [ADDR_MAX_W-1:0]   src_addr;
    logic [PIXEL_W-1:0]      pixel;
    logic [COORD_W-1:0]      cols;
    logic [COORD_W-1:0]      rows;
  } cmd_t;

  typedef struct packed {
    logic valid_a;
    logic valid_b;
  } front_stat_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } queue_stat_t;

endpackage

// ===== src/fbe_front.sv =====
// front end: clips each word against the frame and turns it into a store command
module fbe_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [fbe_pkg::OP_W-1:0]        op,
  input  logic [fbe_pkg::COORD_IN_W-1:0]  left,
  input  logic [fbe_pkg::COORD_IN_W-1:0]  top,
  input  logic [fbe_pkg::COORD_IN_W-1:0]  col_offset,
  input  logic [fbe_pkg::COORD_IN_W-1:0]  row_offset,
  input  logic [fbe_pkg::PIXEL_W-1:0]     pixel,
  input  logic [fbe_pkg::COORD_IN_W-1:0]  src_x,
  input  logic [fbe_pkg::COORD_IN_W-1:0]  src_y,
  input  logic [fbe_pkg::COORD_IN_W-1:0]  right,
  input  logic [fbe_pkg::COORD_IN_W-1:0]  bottom,
  input  logic [fbe_pkg::CFG_W-1:0]       frame_width,
  input  logic [fbe_pkg::CFG_W-1:0]       frame_height,
  output logic                            push,
  output fbe_pkg::cmd_t                   cmd,
  output fbe_pkg::front_stat_t            stat
);
  import fbe_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COORD_W-1:0] xa;
    logic [COORD_W-1:0] ya;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] cols;
    logic [COORD_W-1:0] rows;
    logic [PIXEL_W-1:0] pixel;
  } stage_t;

  function automatic logic [COORD_W-1:0] min3(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b,
                                               input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  logic               va;
  logic               vb;
  stage_t             sa;
  stage_t             sa_next;
  cmd_t               cmd_next;
  logic [COORD_W-1:0] w_eff;
  logic [COORD_W-1:0] h_eff;
  logic [COORD_W-1:0] x_sum;
  logic [COORD_W-1:0] y_sum;
  logic [COORD_W-1:0] row_sel;
  logic [COORD_W-1:0] src_row;
  logic [AW-1:0]      dst;
  logic [AW-1:0]      src;

  // register values above the store size saturate
  assign w_eff = (COORD_W'(frame_width) > COORD_W'(MAX_WIDTH)) ? COORD_W'(MAX_WIDTH)
                                                               : COORD_W'(frame_width);
  assign h_eff = (COORD_W'(frame_height) > COORD_W'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT)
                                                                 : COORD_W'(frame_height);

  assign x_sum = COORD_W'(left) + COORD_W'(col_offset);
  assign y_sum = COORD_W'(top) + COORD_W'(row_offset);

  always_comb begin
    sa_next.kind  = CMD_SKIP;
    sa_next.xa    = COORD_W'(left);
    sa_next.ya    = COORD_W'(top);
    sa_next.sx    = COORD_W'(src_x);
    sa_next.sy    = COORD_W'(src_y);
    sa_next.pixel = pixel;
    // rectangle clipped to both the source and destination edges of the frame
    sa_next.cols  = min3(COORD_W'(right) - COORD_W'(left),
                         w_eff - COORD_W'(src_x), w_eff - COORD_W'(left));
    sa_next.rows  = min3(COORD_W'(bottom) - COORD_W'(top),
                         h_eff - COORD_W'(src_y), h_eff - COORD_W'(top));
    case (op)
      OP_WRITE: begin
        sa_next.xa = x_sum;
        sa_next.ya = y_sum;
        if (x_sum < w_eff && y_sum < h_eff) begin
          sa_next.kind = CMD_WRITE;
        end
      end
      OP_MOVE: begin
        if (right > left && bottom > top &&
            COORD_W'(src_x) < w_eff && COORD_W'(left) < w_eff &&
            COORD_W'(src_y) < h_eff && COORD_W'(top) < h_eff) begin
          sa_next.kind = CMD_MOVE;
        end
      end
      OP_READ: begin
        if (COORD_W'(left) < w_eff && COORD_W'(top) < h_eff) begin
          sa_next.kind = CMD_READ;
        end
      end
      default: ;
    endcase
  end

  // second stage: line flip and linear address
  always_comb begin
    row_sel = (sa.kind == CMD_READ) ? sa.ya : (h_eff - COORD_W'(1) - sa.ya);
    src_row = h_eff - COORD_W'(1) - sa.sy;
    dst     = AW'(row_sel) * AW'(MAX_WIDTH) + AW'(sa.xa);
    src     = AW'(src_row) * AW'(MAX_WIDTH) + AW'(sa.sx);
    cmd_next.kind     = sa.kind;
    cmd_next.dst_addr = ADDR_MAX_W'(dst);
    cmd_next.src_addr = ADDR_MAX_W'(src);
    cmd_next.pixel    = sa.pixel;
    cmd_next.cols     = sa.cols;
    cmd_next.rows     = sa.rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= accept;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sa <= sa_next;
    end
    if (va) begin
      cmd <= cmd_next;
    end
  end

  assign push         = vb;
  assign stat.valid_a = va;
  assign stat.valid_b = vb;

endmodule

// ===== src/fbe_queue.sv =====
// short command queue between the front end and the store sequencer
module fbe_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fbe_pkg::cmd_t        din,
  input  logic                 pop,
  output fbe_pkg::cmd_t        dout,
  output fbe_pkg::queue_stat_t stat
);
  import fbe_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  assign dout       = entries[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== src/fbe_back.sv =====
// back end: frame store, clearing pass, copy sequencer and result register
module fbe_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fbe_pkg::cmd_t                 head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          clearing,
  output logic                          done,
  output logic [fbe_pkg::PIXEL_W-1:0]   read_pixel,
  output logic                          status,
  output logic [fbe_pkg::COUNT_W-1:0]   copied_count
);
  import fbe_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata;

  bk_state_t          state;
  bk_state_t          state_next;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      clr_addr_next;
  logic [AW-1:0]      src_row;
  logic [AW-1:0]      src_row_next;
  logic [AW-1:0]      dst_row;
  logic [AW-1:0]      dst_row_next;
  logic [AW-1:0]      src_cur;
  logic [AW-1:0]      src_cur_next;
  logic [AW-1:0]      dst_cur;
  logic [AW-1:0]      dst_cur_next;
  logic [COORD_W-1:0] cols;
  logic [COORD_W-1:0] cols_next;
  logic [COORD_W-1:0] col_left;
  logic [COORD_W-1:0] col_left_next;
  logic [COORD_W-1:0] row_left;
  logic [COORD_W-1:0] row_left_next;
  logic [COUNT_W-1:0] mv_count;
  logic [COUNT_W-1:0] mv_count_next;

  logic               res_valid;
  logic               res_valid_next;
  logic               res_read;
  logic               res_read_next;
  logic               res_status;
  logic               res_status_next;
  logic [COUNT_W-1:0] res_count;
  logic [COUNT_W-1:0] res_count_next;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [PIXEL_W-1:0] wdata;
  logic [AW-1:0]      raddr;

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    src_row_next    = src_row;
    dst_row_next    = dst_row;
    src_cur_next    = src_cur;
    dst_cur_next    = dst_cur;
    cols_next       = cols;
    col_left_next   = col_left;
    row_left_next   = row_left;
    mv_count_next   = mv_count;
    res_valid_next  = 1'b0;
    res_read_next   = 1'b0;
    res_status_next = res_status;
    res_count_next  = res_count;
    pop             = 1'b0;
    we              = 1'b0;
    waddr           = dst_cur;
    wdata           = rdata;
    raddr           = src_cur;
    case (state)
      BK_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_WRITE: begin
              we              = 1'b1;
              waddr           = head.dst_addr[AW-1:0];
              wdata           = head.pixel;
              res_valid_next  = 1'b1;
              res_status_next = 1'b0;
              res_count_next  = COUNT_W'(1);
            end
            CMD_READ: begin
              raddr           = head.dst_addr[AW-1:0];
              res_valid_next  = 1'b1;
              res_read_next   = 1'b1;
              res_status_next = 1'b0;
              res_count_next  = '0;
            end
            CMD_MOVE: begin
              src_row_next  = head.src_addr[AW-1:0];
              src_cur_next  = head.src_addr[AW-1:0];
              dst_row_next  = head.dst_addr[AW-1:0];
              dst_cur_next  = head.dst_addr[AW-1:0];
              cols_next     = head.cols;
              col_left_next = head.cols;
              row_left_next = head.rows;
              mv_count_next = '0;
              state_next    = BK_MV_RD;
            end
            default: begin
              res_valid_next  = 1'b1;
              res_status_next = 1'b1;
              res_count_next  = '0;
            end
          endcase
        end
      end
      BK_MV_RD: begin
        raddr      = src_cur;
        state_next = BK_MV_WR;
      end
      BK_MV_WR: begin
        // write the word read in the previous cycle, so overlap sees earlier copies
        we            = 1'b1;
        waddr         = dst_cur;
        wdata         = rdata;
        mv_count_next = mv_count + COUNT_W'(1);
        state_next    = BK_MV_RD;
        if (col_left == COORD_W'(1)) begin
          if (row_left == COORD_W'(1)) begin
            res_valid_next  = 1'b1;
            res_status_next = 1'b0;
            res_count_next  = mv_count + COUNT_W'(1);
            state_next      = BK_RUN;
          end else begin
            // next line down is one stored row lower
            src_row_next  = src_row - AW'(MAX_WIDTH);
            src_cur_next  = src_row - AW'(MAX_WIDTH);
            dst_row_next  = dst_row - AW'(MAX_WIDTH);
            dst_cur_next  = dst_row - AW'(MAX_WIDTH);
            col_left_next = cols;
            row_left_next = row_left - COORD_W'(1);
          end
        end else begin
          src_cur_next  = src_cur + AW'(1);
          dst_cur_next  = dst_cur + AW'(1);
          col_left_next = col_left - COORD_W'(1);
        end
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      res_read  <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      res_valid <= res_valid_next;
      res_read  <= res_read_next;
    end
  end

  always_ff @(posedge clk) begin
    src_row    <= src_row_next;
    dst_row    <= dst_row_next;
    src_cur    <= src_cur_next;
    dst_cur    <= dst_cur_next;
    cols       <= cols_next;
    col_left   <= col_left_next;
    row_left   <= row_left_next;
    mv_count   <= mv_count_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  assign clearing     = (state == BK_CLEAR);
  assign done         = res_valid;
  assign read_pixel   = res_read ? rdata : '0;
  assign status       = res_status;
  assign copied_count = res_count;

endmodule

// ===== src/framebuffer_blit_engine_core.sv =====
// top level of the rectangle-copy blit engine
// After reset the frame store is swept to zero, one word a cycle over all
// MAX_WIDTH*MAX_HEIGHT words (65536 at the default size); busy stays high
// through the sweep. A word is taken when start is high and busy is low. Pixel
// writes, reads and clipped or unused commands are taken one a cycle while busy
// stays low, and each gives its result through the front stages, the queue and
// the result register. A rectangle move is set up when popped, then reads and
// writes each copied pixel in turn, the write taking the registered read data;
// words taken behind it wait in a four-entry queue. One result per word, in
// order, on done for exactly one cycle: the receiver cannot stall, so it must
// take every result as it comes. The user must write frame_width and frame_height
// through wr_en only while no word is in flight; the block does not enforce it.
`include "framebuffer_blit_engine_core_defines.svh"
module framebuffer_blit_engine_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fbe_pkg::OP_W-1:0]         op,
  input  logic [fbe_pkg::COORD_IN_W-1:0]   left,
  input  logic [fbe_pkg::COORD_IN_W-1:0]   top,
  input  logic [fbe_pkg::COORD_IN_W-1:0]   col_offset,
  input  logic [fbe_pkg::COORD_IN_W-1:0]   row_offset,
  input  logic [fbe_pkg::PIXEL_W-1:0]      pixel,
  input  logic [fbe_pkg::COORD_IN_W-1:0]   src_x,
  input  logic [fbe_pkg::COORD_IN_W-1:0]   src_y,
  input  logic [fbe_pkg::COORD_IN_W-1:0]   right,
  input  logic [fbe_pkg::COORD_IN_W-1:0]   bottom,
  input  logic                             wr_en,
  input  logic [fbe_pkg::REG_INDEX_W-1:0]  wr_index,
  input  logic [fbe_pkg::CFG_W-1:0]        wr_data,
  output logic                             done,
  output logic [fbe_pkg::PIXEL_W-1:0]      read_pixel,
  output logic                             status,
  output logic [fbe_pkg::COUNT_W-1:0]      copied_count
);
  import fbe_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             accept;
  logic             f_push;
  cmd_t             f_cmd;
  front_stat_t      f_stat;
  cmd_t             q_head;
  queue_stat_t      q_stat;
  logic             q_pop;
  logic             clearing;
  logic [3:0]       pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_SIZE_RESET;
      frame_height <= FRAME_SIZE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_WIDTH:  frame_width  <= wr_data;
        REG_FRAME_HEIGHT: frame_height <= wr_data;
        default: ;
      endcase
    end
  end

  // words in the front stages already own a queue slot
  assign pending = 4'(q_stat.count) + 4'(f_stat.valid_a) + 4'(f_stat.valid_b);
  assign busy    = rst || clearing || (pending >= 4'(QUEUE_DEPTH));
  assign accept  = start && !busy;

  fbe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (op),
    .left         (left),
    .top          (top),
    .col_offset   (col_offset),
    .row_offset   (row_offset),
    .pixel        (pixel),
    .src_x        (src_x),
    .src_y        (src_y),
    .right        (right),
    .bottom       (bottom),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .push         (f_push),
    .cmd          (f_cmd),
    .stat         (f_stat)
  );

  fbe_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .din  (f_cmd),
    .pop  (q_pop),
    .dout (q_head),
    .stat (q_stat)
  );

  fbe_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_empty      (q_stat.empty),
    .pop          (q_pop),
    .clearing     (clearing),
    .done         (done),
    .read_pixel   (read_pixel),
    .status       (status),
    .copied_count (copied_count)
  );

  `FBE_ASSERT_SAME(a_queue_no_overflow, f_push, !q_stat.full, "command queue overflow")
  `FBE_ASSERT_SAME(a_no_result_in_clear, clearing, !done, "result during clearing pass")
  `FBE_ASSERT_SAME(a_failed_result_empty, done && status, read_pixel == '0 && copied_count == '0, "failed word carries data")
  `FBE_ASSERT_NEXT(a_accept_staged, accept, f_stat.valid_a, "accepted word not staged")

endmodule

// ===== tb/sv/framebuffer_blit_engine_core_tb.sv =====
// self-checking testbench for the rectangle-copy blit engine core
module framebuffer_blit_engine_core_tb;
  import fbe_pkg::*;

  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_PHASES = 8;
  localparam int WORDS_PER_PHASE = 250;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [COORD_IN_W-1:0] left;
    logic [COORD_IN_W-1:0] top;
    logic [COORD_IN_W-1:0] col_offset;
    logic [COORD_IN_W-1:0] row_offset;
    logic [PIXEL_W-1:0]    pixel;
    logic [COORD_IN_W-1:0] src_x;
    logic [COORD_IN_W-1:0] src_y;
    logic [COORD_IN_W-1:0] right;
    logic [COORD_IN_W-1:0] bottom;
  } blit_word_t;

  typedef struct {
    logic [PIXEL_W-1:0] pix;
    logic               stat;
    logic [COUNT_W-1:0] cnt;
  } blit_result_t;

  // shadow copy of the frame store plus the results still owed by the core
  class frame_shadow;
    logic [PIXEL_W-1:0] frame [MAX_W*MAX_H];
    int unsigned width_reg;
    int unsigned height_reg;
    blit_result_t owed_results[$];
    int errors;
    int words;
    int results;
    int moves;
    int pixels_copied;

    function new();
      foreach (frame[i]) frame[i] = '0;
      width_reg = 256;
      height_reg = 256;
      errors = 0;
      words = 0;
      results = 0;
      moves = 0;
      pixels_copied = 0;
    endfunction

    function void set_reg(logic [REG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = 32'(val);
      else height_reg = 32'(val);
    endfunction

    function int unsigned eff_w();
      return (width_reg > MAX_W) ? MAX_W : width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg > MAX_H) ? MAX_H : height_reg;
    endfunction

    function void apply_command(blit_word_t c);
      int unsigned fw;
      int unsigned fh;
      int unsigned x;
      int unsigned y;
      int unsigned rw;
      int unsigned rh;
      int unsigned n;
      logic read_hit;
      blit_result_t r;
      fw = eff_w();
      fh = eff_h();
      n = 0;
      read_hit = 1'b0;
      r.pix = '0;
      words++;
      case (c.op)
        OP_WRITE: begin
          x = 32'(c.left) + 32'(c.col_offset);
          y = 32'(c.top) + 32'(c.row_offset);
          if (x < fw && y < fh) begin
            frame[(fh - 1 - y) * MAX_W + x] = c.pixel;
            n = 1;
          end
        end
        OP_MOVE: begin
          moves++;
          if (c.right > c.left && c.bottom > c.top) begin
            rw = 32'(c.right) - 32'(c.left);
            rh = 32'(c.bottom) - 32'(c.top);
            // top-down, left to right: overlapping copies see their own writes
            for (y = 0; y < rh && 32'(c.src_y) + y < fh && 32'(c.top) + y < fh; y++) begin
              for (x = 0; x < rw && 32'(c.src_x) + x < fw && 32'(c.left) + x < fw; x++) begin
                frame[(fh - 1 - (32'(c.top) + y)) * MAX_W + 32'(c.left) + x] =
                  frame[(fh - 1 - (32'(c.src_y) + y)) * MAX_W + 32'(c.src_x) + x];
                n++;
              end
            end
          end
        end
        OP_READ: begin
          // read addresses the stored row directly, bottom line is row 0
          if (32'(c.left) < fw && 32'(c.top) < fh) begin
            r.pix = frame[32'(c.top) * MAX_W + 32'(c.left)];
            read_hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
      pixels_copied += n;
      r.stat = read_hit ? 1'b0 : (n == 0);
      r.cnt = n[COUNT_W-1:0];
      owed_results.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task match_result(logic [PIXEL_W-1:0] pix, logic stat, logic [COUNT_W-1:0] cnt);
      blit_result_t want;
      results++;
      if (owed_results.size() == 0) begin
        report($sformatf("result with no word outstanding (pix %08h st %0b cnt %0d)",
                         pix, stat, cnt));
      end else begin
        want = owed_results.pop_front();
        if (pix !== want.pix)
          report($sformatf("read_pixel %08h, wanted %08h", pix, want.pix));
        if (stat !== want.stat)
          report($sformatf("status %0b, wanted %0b", stat, want.stat));
        if (cnt !== want.cnt)
          report($sformatf("copied_count %0d, wanted %0d", cnt, want.cnt));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [OP_W-1:0]        op = '0;
  logic [COORD_IN_W-1:0]  left = '0;
  logic [COORD_IN_W-1:0]  top = '0;
  logic [COORD_IN_W-1:0]  col_offset = '0;
  logic [COORD_IN_W-1:0]  row_offset = '0;
  logic [PIXEL_W-1:0]     pixel = '0;
  logic [COORD_IN_W-1:0]  src_x = '0;
  logic [COORD_IN_W-1:0]  src_y = '0;
  logic [COORD_IN_W-1:0]  right = '0;
  logic [COORD_IN_W-1:0]  bottom = '0;
  logic                   wr_en = 1'b0;
  logic [REG_INDEX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]       wr_data = '0;
  logic                   done;
  logic [PIXEL_W-1:0]     read_pixel;
  logic                   status;
  logic [COUNT_W-1:0]     copied_count;

  logic idle_en = 1'b1;
  frame_shadow shadow;

  framebuffer_blit_engine_core #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .left(left),
    .top(top),
    .col_offset(col_offset),
    .row_offset(row_offset),
    .pixel(pixel),
    .src_x(src_x),
    .src_y(src_y),
    .right(right),
    .bottom(bottom),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .read_pixel(read_pixel),
    .status(status),
    .copied_count(copied_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done === 1'b1) shadow.match_result(read_pixel, status, copied_count);
  end

  function automatic blit_word_t cmd(logic [OP_W-1:0] o, int unsigned l, int unsigned t,
                                     int unsigned co, int unsigned ro, logic [PIXEL_W-1:0] px,
                                     int unsigned sx, int unsigned sy, int unsigned r,
                                     int unsigned b);
    blit_word_t c;
    c.op = o;
    c.left = l[COORD_IN_W-1:0];
    c.top = t[COORD_IN_W-1:0];
    c.col_offset = co[COORD_IN_W-1:0];
    c.row_offset = ro[COORD_IN_W-1:0];
    c.pixel = px;
    c.src_x = sx[COORD_IN_W-1:0];
    c.src_y = sy[COORD_IN_W-1:0];
    c.right = r[COORD_IN_W-1:0];
    c.bottom = b[COORD_IN_W-1:0];
    return c;
  endfunction

  // mostly near the origin, sometimes at the far edge, now and then anywhere
  function automatic int unsigned pick(int unsigned dim);
    int unsigned r;
    int unsigned e;
    r = $urandom_range(0, 9);
    e = dim + $urandom_range(0, 4);
    if (r == 0) return $urandom_range(0, 4095);
    if (r == 1) return (e >= 3) ? e - 3 : 0;
    return $urandom_range(0, (dim < 12) ? dim : 12);
  endfunction

  function automatic blit_word_t random_word(int unsigned fw, int unsigned fh);
    blit_word_t c;
    int unsigned k;
    int unsigned y;
    int unsigned rw;
    int unsigned rh;
    k = $urandom_range(0, 99);
    c = cmd(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095),
            $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom,
            $urandom_range(0, 4095), $urandom_range(0, 4095),
            $urandom_range(0, 4095), $urandom_range(0, 4095));
    if (k < 40) begin
      c.op = OP_WRITE;
      c.left = COORD_IN_W'(pick(fw));
      c.top = COORD_IN_W'(pick(fh));
      c.col_offset = COORD_IN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                             : $urandom_range(0, 3));
      c.row_offset = COORD_IN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                             : $urandom_range(0, 3));
    end else if (k < 65) begin
      c.op = OP_READ;
      c.left = COORD_IN_W'(pick(fw));
      y = pick(fh);
      c.top = COORD_IN_W'((y < fh) ? fh - 1 - y : y);
    end else if (k < 95) begin
      c.op = OP_MOVE;
      c.left = COORD_IN_W'(pick(fw));
      c.top = COORD_IN_W'(pick(fh));
      c.src_x = COORD_IN_W'(pick(fw));
      c.src_y = COORD_IN_W'(pick(fh));
      if ($urandom_range(0, 59) == 0) begin
        rw = $urandom_range(0, 64);
        rh = $urandom_range(0, 64);
      end else begin
        rw = $urandom_range(0, 8);
        rh = $urandom_range(0, 8);
      end
      c.right = COORD_IN_W'(32'(c.left) + rw);
      c.bottom = COORD_IN_W'(32'(c.top) + rh);
      if ($urandom_range(0, 19) == 0) c.right = COORD_IN_W'($urandom_range(0, 4095));
      if ($urandom_range(0, 19) == 0) c.bottom = COORD_IN_W'($urandom_range(0, 4095));
    end
    return c;
  endfunction

  task automatic send_word(blit_word_t c);
    while (idle_en && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= c.op;
    left <= c.left;
    top <= c.top;
    col_offset <= c.col_offset;
    row_offset <= c.row_offset;
    pixel <= c.pixel;
    src_x <= c.src_x;
    src_y <= c.src_y;
    right <= c.right;
    bottom <= c.bottom;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.apply_command(c);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (shadow.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] fw, logic [CFG_W-1:0] fh);
    wr_en <= 1'b1;
    wr_index <= REG_FRAME_WIDTH;
    wr_data <= fw;
    @(posedge clk);
    shadow.set_reg(REG_FRAME_WIDTH, fw);
    wr_index <= REG_FRAME_HEIGHT;
    wr_data <= fh;
    @(posedge clk);
    shadow.set_reg(REG_FRAME_HEIGHT, fh);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #200_000_000;
    $display("framebuffer_blit_engine_core verification failed");
    $finish;
  end

  initial begin
    int unsigned phase_w [RUN_PHASES];
    int unsigned phase_h [RUN_PHASES];
    phase_w = '{256, 1, 0, 9, 511, 17, 200, 0};
    phase_h = '{256, 1, 7, 0, 300, 9, 255, 0};
    phase_w[RUN_PHASES-1] = $urandom_range(0, 511);
    phase_h[RUN_PHASES-1] = $urandom_range(0, 511);
    shadow = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset frame size; the first one waits out the clear sweep
    send_word(cmd(OP_WRITE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
    send_word(cmd(OP_WRITE, 250, 200, 5, 55, 32'h1234_5678, 0, 0, 0, 0));
    send_word(cmd(OP_WRITE, 4095, 0, 4095, 0, 32'hDEAD_BEEF, 0, 0, 0, 0));
    send_word(cmd(OP_WRITE, 0, 256, 0, 0, 32'hCAFE_F00D, 0, 0, 0, 0));
    send_word(cmd(OP_WRITE, 1, 0, 0, 0, 32'h0000_00A5, 0, 0, 0, 0));
    send_word(cmd(OP_READ, 0, 255, 0, 0, 0, 0, 0, 0, 0));
    send_word(cmd(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(cmd(OP_READ, 256, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(cmd(OP_READ, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF, 4095, 4095, 4095, 4095));
    send_word(cmd(OP_UNUSED, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF, 4095, 4095, 4095, 4095));
    send_word(cmd(OP_MOVE, 5, 5, 0, 0, 0, 0, 0, 5, 9));
    send_word(cmd(OP_MOVE, 0, 9, 0, 0, 0, 0, 0, 4, 3));
    send_word(cmd(OP_MOVE, 300, 0, 0, 0, 0, 0, 0, 310, 5));
    send_word(cmd(OP_MOVE, 0, 0, 0, 0, 0, 4095, 0, 4, 4));
    // overlapping copy smears the first pixel along the row
    send_word(cmd(OP_MOVE, 1, 0, 0, 0, 0, 0, 0, 6, 2));
    send_word(cmd(OP_READ, 5, 255, 0, 0, 0, 0, 0, 0, 0));
    send_word(cmd(OP_MOVE, 250, 198, 0, 0, 0, 0, 0, 262, 202));
    send_word(cmd(OP_READ, 250, 57, 0, 0, 0, 0, 0, 0, 0));
    send_word(cmd(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 4095, 4095));
    send_word(cmd(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(cmd(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    for (int p = 0; p < RUN_PHASES; p++) begin
      set_frame(CFG_W'(phase_w[p]), CFG_W'(phase_h[p]));
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // one quiet stretch with no idling in the middle of the run
        idle_en = !(p == 3 && i >= 20);
        if (p == 0 && i == WORDS_PER_PHASE / 2) drain();
        send_word(random_word(shadow.eff_w(), shadow.eff_h()));
      end
      drain();
    end

    $display("ran %0d words (%0d moves, %0d pixels copied) across %0d frame sizes",
             shadow.words, shadow.moves, shadow.pixels_copied, RUN_PHASES + 1);
    $display("checked %0d results, %0d mismatches", shadow.results, shadow.errors);
    if (shadow.errors == 0 && shadow.owed_results.size() == 0) begin
      $display("framebuffer_blit_engine_core verification clean");
    end else begin
      $display("framebuffer_blit_engine_core verification failed");
    end
    $finish;
  end

endmodule
